// ----- hw/rtl/mbfc_pkg.sv -----
// Shared types, opcode codes and decode helpers for the branch flow classifier.
package mbfc_pkg;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [31:0] HALT_WORD   = 32'h7C1C97C0;
  localparam logic [31:0] REGION_MASK = 32'hF0000000;
  localparam logic [4:0]  COP0_CO_BIT = 5'h10;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_COP0    = 6'd16;
  localparam logic [5:0] OP_COP1    = 6'd17;
  localparam logic [5:0] OP_BEQL    = 6'd20;
  localparam logic [5:0] OP_BNEL    = 6'd21;
  localparam logic [5:0] OP_BLEZL   = 6'd22;
  localparam logic [5:0] OP_BGTZL   = 6'd23;

  // SPECIAL function codes
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_BREAK   = 6'd13;

  // REGIMM rt codes
  localparam logic [4:0] RT_BLTZ    = 5'd0;
  localparam logic [4:0] RT_BGEZ    = 5'd1;
  localparam logic [4:0] RT_BLTZL   = 5'd2;
  localparam logic [4:0] RT_BGEZL   = 5'd3;
  localparam logic [4:0] RT_BGEZAL  = 5'd17;

  // COP0 / COP1 codes
  localparam logic [4:0] RS_MF      = 5'd0;
  localparam logic [4:0] RS_MT      = 5'd4;
  localparam logic [4:0] RS_BC      = 5'd8;
  localparam logic [5:0] FN_TLBR    = 6'd1;
  localparam logic [5:0] FN_TLBWI   = 6'd2;
  localparam logic [5:0] FN_TLBWR   = 6'd6;
  localparam logic [5:0] FN_TLBP    = 6'd8;
  localparam logic [5:0] FN_ERET    = 6'd24;
  localparam logic [4:0] BC_F       = 5'd0;
  localparam logic [4:0] BC_T       = 5'd1;
  localparam logic [4:0] BC_FL      = 5'd2;
  localparam logic [4:0] BC_TL      = 5'd3;

  typedef struct packed {
    logic        recognized;
    logic        has_target;
    logic [31:0] target_addr;
    logic        has_fallthrough;
    logic [31:0] fallthrough_addr;
    logic        likely_kind;
    logic        uses_delay_slot;
    logic        ends_block;
    logic        self_loop;
  } flow_t;

  // SPECIAL functions that do not touch control flow
  function automatic logic special_plain(input logic [5:0] fn);
    logic ok;
    unique case (fn) inside
      6'd0, 6'd2, 6'd3, 6'd4, 6'd6, 6'd7,
      [6'd16:6'd20], 6'd22, [6'd23:6'd39],
      [6'd42:6'd47],
      6'd56, 6'd58, 6'd59, 6'd60, 6'd62, 6'd63: ok = 1'b1;
      default:                                  ok = 1'b0;
    endcase
    return ok;
  endfunction

  // immediate-form, load and store opcodes with no control flow
  function automatic logic imm_plain(input logic [5:0] op);
    logic ok;
    unique case (op) inside
      [6'd8:6'd15], [6'd24:6'd27], [6'd32:6'd47],
      6'd49, 6'd53, 6'd55, 6'd57, 6'd61, 6'd63: ok = 1'b1;
      default:                                  ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ----- hw/rtl/mbfc_decode.sv -----
// Combinational control-flow classification of one instruction word.
module mbfc_decode (
  input  logic [31:0]   pc,
  input  logic [31:0]   instr_word,
  input  logic          slot_hits_compare,
  output mbfc_pkg::flow_t flow
);
  import mbfc_pkg::*;

  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [5:0]  fn;
  logic [31:0] dest;
  logic [31:0] pc_plus8;
  logic [31:0] jump_tgt;
  logic        to_next;
  logic        to_self;

  // branch request collected by the case, resolved once below
  logic br_req;
  logic br_likely;
  logic br_cont;
  logic br_loop_test;
  logic br_take;

  logic rec;
  logic endb;
  logic slot_only;
  logic j_kind;

  assign op       = instr_word[31:26];
  assign rs       = instr_word[25:21];
  assign rt       = instr_word[20:16];
  assign fn       = instr_word[5:0];
  assign dest     = pc + {{14{instr_word[15]}}, instr_word[15:0], 2'b00} + 32'd4;
  assign pc_plus8 = pc + 32'd8;
  assign jump_tgt = (pc & REGION_MASK) + {4'b0000, instr_word[25:0], 2'b00};
  // offset of +1 word lands on pc+8, offset of -1 word lands on pc
  assign to_next  = (instr_word[15:0] == 16'h0001);
  assign to_self  = (instr_word[15:0] == 16'hFFFF);

  always_comb begin
    rec          = 1'b1;
    endb         = 1'b0;
    slot_only    = 1'b0;
    j_kind       = 1'b0;
    br_req       = 1'b0;
    br_likely    = 1'b0;
    br_cont      = 1'b1;
    br_loop_test = 1'b1;
    unique case (op) inside
      OP_SPECIAL: begin
        if (fn == FN_JR || fn == FN_JALR) begin
          endb      = 1'b1;
          slot_only = 1'b1;
        end else if (fn == FN_SYSCALL || fn == FN_BREAK) begin
          endb = 1'b1;
        end else if (!special_plain(fn)) begin
          rec = 1'b0;
        end
      end
      OP_REGIMM: begin
        if (rt == RT_BLTZ) begin
          br_req = 1'b1;
        end else if (rt == RT_BGEZ || rt == RT_BGEZAL) begin
          if (!to_next) begin
            if (to_self && rs == 5'd0) begin
              // unconditional spin on r0
              endb      = 1'b1;
              slot_only = 1'b1;
            end else begin
              br_req  = 1'b1;
              br_cont = (rs != 5'd0);
            end
          end
        end else if (rt == RT_BLTZL || rt == RT_BGEZL) begin
          br_req    = 1'b1;
          br_likely = 1'b1;
        end else begin
          rec = 1'b0;
        end
      end
      OP_J: begin
        j_kind = 1'b1;
      end
      OP_JAL: begin
        endb      = 1'b1;
        slot_only = 1'b1;
      end
      OP_BEQ: begin
        br_req  = 1'b1;
        br_cont = ((rs | rt) != 5'd0);
      end
      OP_BNE, OP_BLEZ, OP_BGTZ: begin
        br_req = 1'b1;
      end
      OP_COP0: begin
        if (rs != RS_MF && rs != RS_MT) begin
          if ((rs & COP0_CO_BIT) == 5'd0) begin
            rec = 1'b0;
          end else if (fn == FN_ERET) begin
            endb = 1'b1;
          end else if (fn != FN_TLBR && fn != FN_TLBWI && fn != FN_TLBWR
                       && fn != FN_TLBP) begin
            rec = 1'b0;
          end
        end
      end
      OP_COP1: begin
        case (rs) inside
          5'd0, 5'd1, 5'd2, 5'd4, 5'd5, 5'd6,
          5'd16, 5'd17, 5'd20, 5'd21: ;
          RS_BC: begin
            br_loop_test = 1'b0;
            if (rt == BC_F || rt == BC_T) begin
              br_req = 1'b1;
            end else if (rt == BC_FL || rt == BC_TL) begin
              br_req    = 1'b1;
              br_likely = 1'b1;
            end
          end
          default: rec = 1'b0;
        endcase
      end
      OP_BEQL: begin
        br_req    = 1'b1;
        br_likely = 1'b1;
        br_cont   = ((rs | rt) != 5'd0);
      end
      OP_BNEL, OP_BLEZL, OP_BGTZL: begin
        br_req    = 1'b1;
        br_likely = 1'b1;
      end
      default: begin
        if (!imm_plain(op)) begin
          if (instr_word == HALT_WORD) endb = 1'b1;
          else rec = 1'b0;
        end
      end
    endcase
  end

  // ordinary branches to pc+8 vanish; likely ones always stand
  assign br_take = br_req && (br_likely || !to_next);

  always_comb begin
    flow                  = '0;
    if (rec) begin
      flow.recognized      = 1'b1;
      flow.has_target      = br_take || j_kind;
      flow.target_addr     = j_kind ? jump_tgt : (br_take ? dest : 32'd0);
      flow.has_fallthrough = br_take && br_cont;
      flow.fallthrough_addr = (br_take && br_cont) ? pc_plus8 : 32'd0;
      flow.likely_kind     = br_take && br_likely;
      flow.uses_delay_slot = br_take || j_kind || slot_only;
      flow.ends_block      = endb;
      flow.self_loop       = (j_kind && jump_tgt == pc)
                             || (br_take && br_loop_test && to_self && !slot_hits_compare);
    end
  end

endmodule

// ----- hw/rtl/mips_branch_flow_classifier_unit.sv -----
// Top level: registered stream wrapper around the branch flow decoder.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_tvalid/in_tready   | in_tdata: pc, instr_word, slot_hits_compare
//  out_    | output    | out_tvalid/out_tready | out_tdata: flow classification
//
// One transaction per cycle sustained while the output is not stalled; data passes
// through the input register, then is decoded into the output register. Both stages
// advance whenever the output register is empty or being drained, so a stalled
// output backs up through in_tready. rst_n clears only the stage valid bits.
module mips_branch_flow_classifier_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] pc, [63:32] instr_word, [64] slot_hits_compare, [71:65] zero
  input  logic [mbfc_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] recognized, [1] has_target, [33:2] target_addr, [34] has_fallthrough,
  // [66:35] fallthrough_addr, [67] likely_kind, [68] uses_delay_slot,
  // [69] ends_block, [70] self_loop, [71] zero
  output logic [mbfc_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import mbfc_pkg::*;

  logic        s1_valid_r;
  logic [31:0] s1_pc_r;
  logic [31:0] s1_word_r;
  logic        s1_hit_r;
  logic        out_valid_r;
  flow_t       out_flow_r;
  flow_t       dec_flow;
  logic        out_load;
  logic        s1_load;

  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign s1_load   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (!out_valid_r || out_tready) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pc_r   <= in_tdata[31:0];
      s1_word_r <= in_tdata[63:32];
      s1_hit_r  <= in_tdata[64];
    end
    if (out_load) out_flow_r <= dec_flow;
  end

  mbfc_decode u_decode (
    .pc                (s1_pc_r),
    .instr_word        (s1_word_r),
    .slot_hits_compare (s1_hit_r),
    .flow              (dec_flow)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0,
                       out_flow_r.self_loop,
                       out_flow_r.ends_block,
                       out_flow_r.uses_delay_slot,
                       out_flow_r.likely_kind,
                       out_flow_r.fallthrough_addr,
                       out_flow_r.has_fallthrough,
                       out_flow_r.target_addr,
                       out_flow_r.has_target,
                       out_flow_r.recognized};

endmodule
